FILE: rtl/ppp_pkg.sv
// Shared types, constants and register codes for the packed pixel plot unit.
// No dependencies; imported by every module in rtl/.
package ppp_pkg;

    localparam int SCREEN_SIDE = 128;
    localparam int COORD_W     = $clog2(SCREEN_SIDE);
    localparam int LIN_W       = $clog2(SCREEN_SIDE * SCREEN_SIDE);
    localparam int STORE_BYTES = (SCREEN_SIDE * SCREEN_SIDE + 1) / 2;
    localparam int ADDR_W      = LIN_W - 1;

    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TMASK     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_L    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_T    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_R    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_B    = 4'd7;

    // reset values
    localparam logic [63:0] PALETTE_RST = 64'hFEDC_BA98_7654_3210;
    localparam logic [15:0] TMASK_RST   = 16'h0001;
    localparam logic [7:0]  CLIP_LO_RST = 8'd0;
    localparam logic [7:0]  CLIP_HI_RST = 8'd128;

    // opcodes
    localparam logic [1:0] OP_PLOT   = 2'd0;
    localparam logic [1:0] OP_SPRITE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    typedef struct packed {
        logic [63:0] palette;
        logic [15:0] tmask;
        logic [15:0] cam_x;
        logic [15:0] cam_y;
        logic [7:0]  clip_l;
        logic [7:0]  clip_t;
        logic [7:0]  clip_r;
        logic [7:0]  clip_b;
    } t_cfg;

    // decoded pixel operation
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              high;
        logic              do_write;
        logic              do_read;
        logic [3:0]        color;
    } t_pix;

endpackage

FILE: rtl/ppp_frame_ram.sv
// Framebuffer byte store: one write port, one registered read port.
// Depends on ppp_pkg for depth and address width.
module ppp_frame_ram
    import ppp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data
);

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read-before-write on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/ppp_cfg_regs.sv
// Configuration register file for the packed pixel plot unit.
// Depends on ppp_pkg for t_cfg and register indexes.
module ppp_cfg_regs
    import ppp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.palette <= PALETTE_RST;
            r_cfg.tmask   <= TMASK_RST;
            r_cfg.cam_x   <= '0;
            r_cfg.cam_y   <= '0;
            r_cfg.clip_l  <= CLIP_LO_RST;
            r_cfg.clip_t  <= CLIP_LO_RST;
            r_cfg.clip_r  <= CLIP_HI_RST;
            r_cfg.clip_b  <= CLIP_HI_RST;
        end else if (i_wr) begin
            case (i_index)
                REG_PALETTE:  r_cfg.palette <= i_data;
                REG_TMASK:    r_cfg.tmask   <= i_data[15:0];
                REG_CAMERA_X: r_cfg.cam_x   <= i_data[15:0];
                REG_CAMERA_Y: r_cfg.cam_y   <= i_data[15:0];
                REG_CLIP_L:   r_cfg.clip_l  <= i_data[7:0];
                REG_CLIP_T:   r_cfg.clip_t  <= i_data[7:0];
                REG_CLIP_R:   r_cfg.clip_r  <= i_data[7:0];
                REG_CLIP_B:   r_cfg.clip_b  <= i_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/ppp_pixel_front.sv
// Pixel decode: camera offset, clip test, byte address, palette and transparency.
// Depends on ppp_pkg for t_cfg, t_pix and opcodes.
module ppp_pixel_front
    import ppp_pkg::*;
(
    input  t_cfg        i_cfg,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic [3:0]  i_pen_color,
    output t_pix        o_pix
);

    logic [16:0]      w_x;
    logic [16:0]      w_y;
    logic             w_x_ok;
    logic             w_y_ok;
    logic             w_vis;
    logic [LIN_W-1:0] w_lin;
    logic             w_opaque;

    // 17-bit two's complement; bit 16 is the sign
    assign w_x = {i_pos_x[15], i_pos_x} - {i_cfg.cam_x[15], i_cfg.cam_x};
    assign w_y = {i_pos_y[15], i_pos_y} - {i_cfg.cam_y[15], i_cfg.cam_y};

    assign w_x_ok = !w_x[16]
                 && (w_x[15:0] >= 16'(i_cfg.clip_l))
                 && (w_x[15:0] <  16'(i_cfg.clip_r))
                 && (w_x[15:0] <  16'(SCREEN_SIDE));
    assign w_y_ok = !w_y[16]
                 && (w_y[15:0] >= 16'(i_cfg.clip_t))
                 && (w_y[15:0] <  16'(i_cfg.clip_b))
                 && (w_y[15:0] <  16'(SCREEN_SIDE));
    assign w_vis  = w_x_ok && w_y_ok;

    assign w_lin = LIN_W'(w_y[COORD_W-1:0]) * LIN_W'(SCREEN_SIDE)
                 + LIN_W'(w_x[COORD_W-1:0]);

    assign w_opaque = !i_cfg.tmask[i_pen_color];

    assign o_pix.addr     = w_lin[LIN_W-1:1];
    assign o_pix.high     = w_lin[0];
    assign o_pix.do_write = w_vis
                         && ((i_op == OP_PLOT) || ((i_op == OP_SPRITE) && w_opaque));
    assign o_pix.do_read  = w_vis && (i_op == OP_READ);
    assign o_pix.color    = i_cfg.palette[i_pen_color*4 +: 4];

endmodule

FILE: rtl/packed_pixel_plot_unit_core.sv
// Packed 4bpp pixel plotter: 128x128 framebuffer, two pixels per byte.
// Path: stage 1, then the output register (o_out_valid); two beats in flight fill the pipe.
// Throughput: one pixel per cycle unless output stalls or clearing runs; RAM read on the input
//   edge, write-back as the beat leaves stage 1, one-entry forward for back-to-back byte hits.
// Reset (i_rst_n low, synchronous): registers return to defaults, then a clearing pass
//   zeroes all STORE_BYTES (8192) bytes of the frame RAM; input is held off meanwhile.
module packed_pixel_plot_unit_core
    import ppp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel operation channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_op,
    input  logic signed [15:0]    i_pos_x,
    input  logic signed [15:0]    i_pos_y,
    input  logic [3:0]            i_pen_color,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [3:0]            o_read_color,
    output logic                  o_written
);

    t_cfg w_cfg;
    t_pix w_front;

    // Stage 1: decoded item, its RAM read data arrives alongside
    logic              r_s1_valid;
    t_pix              r_s1;
    logic              r_fwd_hit;
    logic [7:0]        r_fwd_byte;

    // Output register
    logic              r_out_valid;
    logic [3:0]        r_out_color;
    logic              r_out_written;

    // Clearing pass
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              w_accept;
    logic              w_s1_adv;
    logic [7:0]        w_rd_data;
    logic [7:0]        w_cur;
    logic [7:0]        w_new;
    logic [3:0]        w_nib;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [7:0]        w_wr_data;

    // Config writes are always taken, even during the clearing pass
    assign o_cfg_ready = 1'b1;

    ppp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    ppp_pixel_front u_front (
        .i_cfg       (w_cfg),
        .i_op        (i_op),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pen_color (i_pen_color),
        .o_pix       (w_front)
    );

    // Stage 1 moves on when the output register is empty or draining this cycle
    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clearing && (!r_s1_valid || w_s1_adv);
    assign w_accept   = i_in_valid && o_in_ready;

    // Byte as seen by stage 1: forwarded if the previous beat wrote the same byte
    // on the edge where this one issued its read
    assign w_cur = r_fwd_hit ? r_fwd_byte : w_rd_data;
    assign w_new = r_s1.high ? {r_s1.color, w_cur[3:0]} : {w_cur[7:4], r_s1.color};
    assign w_nib = r_s1.high ? w_cur[7:4] : w_cur[3:0];

    // Write port: clearing pass owns it after reset
    assign w_wr_en   = r_clearing || (w_s1_adv && r_s1.do_write);
    assign w_wr_addr = r_clearing ? r_clr_addr : r_s1.addr;
    assign w_wr_data = r_clearing ? 8'h00 : w_new;

    ppp_frame_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_front.addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    // Clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ADDR_W'(STORE_BYTES - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= w_s1_adv && r_s1.do_write && (r_s1.addr == w_front.addr);
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
                r_fwd_hit  <= 1'b0;
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1       <= w_front;
            r_fwd_byte <= w_new;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_color   <= r_s1.do_read ? w_nib : 4'h0;
            r_out_written <= r_s1.do_write;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_color = r_out_color;
    assign o_written    = r_out_written;

    // A forward only ever belongs to a live stage-1 beat
    a_fwd_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r_s1_valid)
        else $error("forward flag set with empty stage 1");

    // Nothing in flight while the RAM is being swept
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (!r_s1_valid && !r_out_valid))
        else $error("pixel beat in flight during clearing pass");

    // A write beat never carries read data
    a_rd_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_written) |-> (o_read_color == 4'h0))
        else $error("write result carries a read color");

    // A stage-1 write always reaches the RAM the cycle it leaves
    a_wr_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && r_s1.do_write) |-> (w_wr_en && !r_clearing))
        else $error("stage-1 write dropped");

endmodule
